/* rtl/radix_digit_converter_top_macros.svh */
// Assertion macros shared by the radix digit converter RTL.
`ifndef RADIX_DIGIT_CONVERTER_TOP_MACROS_SVH
`define RADIX_DIGIT_CONVERTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RDC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/rdc_pkg.sv */
// Types, constants and reciprocal table of the radix digit converter.
package rdc_pkg;

  localparam int VALUE_W   = 31;
  localparam int RADIX_W   = 5;
  localparam int DIGIT_W   = 4;
  localparam int RECIP_W   = 32;
  localparam int PROD_W    = VALUE_W + RECIP_W;
  localparam int SHIFT_W   = 3;
  localparam int SHIFT_AW  = 6;
  localparam int FRAC_BASE = VALUE_W;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd2;

  localparam int APB_DW = 32;
  localparam int APB_AW = 3;
  localparam logic [APB_AW-1:0] ADDR_RADIX = 3'd0;

  // Reciprocal m = ceil(2^(31+l) / r), l = ceil(log2 r); floor(x*m >> (31+l)) == x / r
  // for every 31-bit x.
  typedef struct packed {
    logic [RECIP_W-1:0] mult;
    logic [SHIFT_W-1:0] shift;
  } recip_t;

  typedef struct packed {
    logic load;
    logic prep;
    logic div;
    logic pop;
  } rdc_cmd_t;

  typedef struct packed {
    logic value_nz;
    logic div_done;
    logic pop_last;
  } rdc_status_t;

  function automatic logic [RADIX_W-1:0] eff_radix(input logic [RADIX_W-1:0] r);
    logic [RADIX_W-1:0] e;
    e = r;
    if (r < RADIX_MIN) e = RADIX_MIN;
    else if (r > RADIX_MAX) e = RADIX_MAX;
    return e;
  endfunction

  function automatic recip_t recip_lookup(input logic [RADIX_W-1:0] r);
    recip_t t;
    case (r)
      5'd2:    t = '{mult: 32'h8000_0000, shift: 3'd1};
      5'd3:    t = '{mult: 32'hAAAA_AAAB, shift: 3'd2};
      5'd4:    t = '{mult: 32'h8000_0000, shift: 3'd2};
      5'd5:    t = '{mult: 32'hCCCC_CCCD, shift: 3'd3};
      5'd6:    t = '{mult: 32'hAAAA_AAAB, shift: 3'd3};
      5'd7:    t = '{mult: 32'h9249_2493, shift: 3'd3};
      5'd8:    t = '{mult: 32'h8000_0000, shift: 3'd3};
      5'd9:    t = '{mult: 32'hE38E_38E4, shift: 3'd4};
      5'd10:   t = '{mult: 32'hCCCC_CCCD, shift: 3'd4};
      5'd11:   t = '{mult: 32'hBA2E_8BA3, shift: 3'd4};
      5'd12:   t = '{mult: 32'hAAAA_AAAB, shift: 3'd4};
      5'd13:   t = '{mult: 32'h9D89_D89E, shift: 3'd4};
      5'd14:   t = '{mult: 32'h9249_2493, shift: 3'd4};
      5'd15:   t = '{mult: 32'h8888_8889, shift: 3'd4};
      5'd16:   t = '{mult: 32'h8000_0000, shift: 3'd4};
      default: t = '{mult: 32'h8000_0000, shift: 3'd1};
    endcase
    return t;
  endfunction

endpackage

/* rtl/rdc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
  parameter int DATA_W = 4,
  parameter int DEPTH  = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/rdc_ctrl.sv */
// Sequencer of the radix digit converter: load, prime the product, divide, pop.
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  rdc_status_t status,
  output rdc_cmd_t    cmd,
  output logic        busy
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_PREP = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_POP  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start && status.value_nz) begin
          cmd.load  = 1'b1;
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        cmd.prep  = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div = 1'b1;
        if (status.div_done) state_nxt = ST_POP;
      end
      ST_POP: begin
        cmd.pop = 1'b1;
        if (status.pop_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != ST_IDLE);

endmodule

/* rtl/rdc_datapath.sv */
// Datapath: reciprocal divider, digit stack and output registers.
module rdc_datapath
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  rdc_cmd_t           cmd,
  input  logic [VALUE_W-1:0] in_value,
  input  logic [RADIX_W-1:0] radix,
  output rdc_status_t        status,
  output logic               out_valid,
  output logic [DIGIT_W-1:0] out_digit,
  output logic               out_last
);

  localparam int AW    = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  logic [VALUE_W-1:0]         quot_r;
  logic [RADIX_W-1:0]         radix_r;
  logic [RECIP_W-1:0]         mult_r;
  logic [SHIFT_W-1:0]         shift_r;
  logic [PROD_W-1:0]          prod_r;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic                       rd_valid_r, rd_last_r;

  recip_t                     recip_s;
  logic [RADIX_W-1:0]         eff_s;
  logic [SHIFT_AW-1:0]        shift_amt;
  logic [VALUE_W-1:0]         q_s;
  logic [VALUE_W+RADIX_W-1:0] qr_s;
  logic [VALUE_W-1:0]         diff_s;
  logic [VALUE_W-1:0]         mul_in;
  logic [CNT_W-1:0]           cnt_dec;

  assign eff_s   = eff_radix(radix);
  assign recip_s = recip_lookup(eff_s);

  // Quotient from the registered product, remainder by back-multiplication.
  assign shift_amt = SHIFT_AW'(FRAC_BASE) + SHIFT_AW'(shift_r);
  assign q_s       = VALUE_W'(prod_r >> shift_amt);
  assign qr_s      = (VALUE_W + RADIX_W)'(q_s) * (VALUE_W + RADIX_W)'(radix_r);
  assign diff_s    = quot_r - qr_s[VALUE_W-1:0];
  assign mul_in    = cmd.div ? q_s : quot_r;
  assign cnt_dec   = cnt_r - CNT_W'(1);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      quot_r  <= in_value;
      radix_r <= eff_s;
      mult_r  <= recip_s.mult;
      shift_r <= recip_s.shift;
    end else if (cmd.div) begin
      quot_r <= q_s;
    end
    if (cmd.prep || cmd.div) begin
      prod_r <= PROD_W'(mul_in) * PROD_W'(mult_r);
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    if (cmd.load)     cnt_nxt = '0;
    else if (cmd.div) cnt_nxt = cnt_r + CNT_W'(1);
    else if (cmd.pop) cnt_nxt = cnt_dec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r      <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      cnt_r      <= cnt_nxt;
      rd_valid_r <= cmd.pop;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      rd_last_r <= (cnt_dec == '0);
    end
  end

  rdc_ram #(
    .DATA_W (DIGIT_W),
    .DEPTH  (MAX_DIGITS)
  ) u_stack (
    .clk   (clk),
    .we    (cmd.div),
    .waddr (cnt_r[AW-1:0]),
    .wdata (diff_s[DIGIT_W-1:0]),
    .re    (cmd.pop),
    .raddr (cnt_dec[AW-1:0]),
    .rdata (out_digit)
  );

  assign status.value_nz = (in_value != '0);
  assign status.div_done = (q_s == '0) || (cnt_r == CNT_W'(MAX_DIGITS - 1));
  assign status.pop_last = (cnt_r == CNT_W'(1));

  assign out_valid = rd_valid_r;
  assign out_last  = rd_last_r;

endmodule

/* rtl/radix_digit_converter_top.sv */
// Top level of the radix digit converter: APB register, sequencer and datapath.
//
// Usage:
//   Input channel: drive in_value and raise start; the transaction is taken at
//   a rising edge with start high and busy low. A value of zero produces no
//   digits and the block stays idle.
//   Result channel: each digit appears on out_digit for exactly one cycle with
//   out_valid high, most significant digit first; out_last marks the final,
//   least significant digit. The receiver cannot stall; every strobe is taken.
//   Config: one APB register at address 0, radix (5 bits, reset 2). Values
//   below 2 act as 2, values above 16 act as 16. Write only while idle.
// Operation:
//   a prime step forms the first reciprocal product, the divide phase yields the
//   digits (one digit per cycle through the 31x32 reciprocal multiplier), and the pop
//   phase reads the digit stack back (one RAM read per cycle). busy stays high through
//   the prime, divide and pop phases. A new transaction may be accepted while the last
//   digit is on the outputs.
// Reset: synchronous, active low; returns to idle, drops pending strobes and
//   restores radix to 2. Stack contents need no clearing.
module radix_digit_converter_top
  import rdc_pkg::*;
#(
  parameter int MAX_DIGITS = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic [VALUE_W-1:0] in_value,
  // result channel
  output logic               out_valid,
  output logic [DIGIT_W-1:0] out_digit,
  output logic               out_last,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

`include "radix_digit_converter_top_macros.svh"

  logic [RADIX_W-1:0] radix_r;
  rdc_cmd_t           cmd;
  rdc_status_t        status;
  logic               cfg_wr;

  // Register write completes in the access phase; pready never waits.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_RESET;
    end else if (cfg_wr && (paddr == ADDR_RADIX)) begin
      radix_r <= pwdata[RADIX_W-1:0];
    end
  end

  // Read decode: return the raw register, zero elsewhere.
  always_comb begin
    unique case (paddr)
      ADDR_RADIX: prdata = APB_DW'(radix_r);
      default:    prdata = '0;
    endcase
  end

  // Sequence each transaction: load, prime the product, divide, pop.
  rdc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // Divide by reciprocal, push remainders, then read them back in reverse.
  rdc_datapath #(
    .MAX_DIGITS (MAX_DIGITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_value  (in_value),
    .radix     (radix_r),
    .status    (status),
    .out_valid (out_valid),
    .out_digit (out_digit),
    .out_last  (out_last)
  );

  // Digits of one run come out on consecutive cycles.
  `RDC_ASSERT_NEXT(a_digits_contiguous, clk, rst_n, out_valid && !out_last, out_valid,
    "digit strobe gap inside a run")

  // After the final digit no further strobe follows right away.
  `RDC_ASSERT_NEXT(a_last_ends_run, clk, rst_n, out_valid && out_last, !out_valid,
    "strobe right after the final digit")

  // An accepted nonzero value keeps the block busy and silent next cycle.
  `RDC_ASSERT_NEXT(a_accept_busy, clk, rst_n, start && !busy && (in_value != '0),
    busy && !out_valid, "accepted transaction did not start work")

  // Zero input never starts a run.
  `RDC_ASSERT_NEXT(a_zero_idle, clk, rst_n, start && !busy && (in_value == '0),
    !busy, "zero value started a run")

endmodule
